// ===== rtl/hid_descriptor_usage_rewriter_macros.svh =====
// Assertion macros used by the checker file.
`ifndef HID_DESCRIPTOR_USAGE_REWRITER_MACROS_SVH
`define HID_DESCRIPTOR_USAGE_REWRITER_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted
`define HDUR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("hdur check failed");

// Next-cycle implication, ignored while reset is asserted
`define HDUR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("hdur check failed");

// Next-cycle implication that also holds through reset
`define HDUR_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hdur check failed");

`endif

// ===== rtl/hdur_pkg.sv =====
// ----------------------------------------------------------------------------
// hdur_pkg
// Types, codes and helpers for the HID descriptor usage rewriter.
// ----------------------------------------------------------------------------
package hdur_pkg;

  localparam int unsigned LenW   = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PhaseW = 3;

  // parse phases
  localparam logic [PhaseW-1:0] PH_HEADER     = 3'd0;
  localparam logic [PhaseW-1:0] PH_LONG_SIZE  = 3'd1;
  localparam logic [PhaseW-1:0] PH_LONG_TAG   = 3'd2;
  localparam logic [PhaseW-1:0] PH_LOCAL_BYTE = 3'd3;
  localparam logic [PhaseW-1:0] PH_SKIP       = 3'd4;

  localparam logic [3:0] TAG_LONG   = 4'hF;
  localparam logic [1:0] TYPE_LOCAL = 2'd2;

  localparam logic [ByteW-1:0] USAGE_JOY   = 8'h04;
  localparam logic [ByteW-1:0] USAGE_PAD   = 8'h05;
  localparam logic [ByteW-1:0] USAGE_MULTI = 8'h08;

  localparam logic [LenW-1:0] POS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             first;
  } hdur_in_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             rewritten;
    logic             invalid;
    logic             last;
  } hdur_out_t;

  // data byte count of a short item from its size code
  function automatic logic [2:0] short_size(input logic [1:0] code);
    logic [2:0] res;
    case (code)
      2'd0:    res = 3'd0;
      2'd1:    res = 3'd1;
      2'd2:    res = 3'd2;
      2'd3:    res = 3'd4;
      default: res = 3'd0;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/hid_descriptor_usage_rewriter.sv =====
// ----------------------------------------------------------------------------
// hid_descriptor_usage_rewriter
// Walks a HID report descriptor and rewrites joystick/gamepad usages.
// ----------------------------------------------------------------------------
// Takes one descriptor byte per beat and returns one result beat for each,
// in the cycle after acceptance. A new byte is accepted every cycle while the
// result register is empty or being drained, so the sustained rate is one
// byte per clock; the only state carried between bytes is the parse phase,
// byte position, skip count and stop flag, updated in the cycle of acceptance.
// cfg_wdata sets the descriptor length; write it only while no beat is in
// flight. A beat with first set restarts the parse at byte 0.
module hid_descriptor_usage_rewriter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hdur_pkg::hdur_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hdur_pkg::hdur_out_t  out_data
);

  logic                step;
  hdur_pkg::hdur_out_t result;

  assign step = in_valid && in_ready;

  hdur_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .step     (step),
    .beat_in  (in_data),
    .beat_out (result)
  );

  hdur_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step),
    .load_data(result),
    .can_load (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== rtl/hdur_parser.sv =====
// ----------------------------------------------------------------------------
// hdur_parser
// Item walker: holds parse state and length, works out one beat's result.
// ----------------------------------------------------------------------------
module hdur_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  input  logic                 step,
  input  hdur_pkg::hdur_in_t   beat_in,
  output hdur_pkg::hdur_out_t  beat_out
);

  logic [15:0] len_r;
  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic        stop_r, stop_nxt;

  logic [2:0]  phase_cur;
  logic [15:0] pos_cur;
  logic [7:0]  skip_cur, skip_dec;
  logic        stop_cur;
  logic [7:0]  d;
  logic [2:0]  ds;
  logic [17:0] pos_ext, short_end, long_hdr_end, long_end, len_ext;
  logic        in_range;

  always_comb begin
    d = beat_in.data_byte;
    // a first beat restarts from the header phase at byte 0
    phase_cur = beat_in.first ? hdur_pkg::PH_HEADER : phase_r;
    pos_cur   = beat_in.first ? 16'd0 : pos_r;
    skip_cur  = beat_in.first ? 8'd0 : skip_r;
    stop_cur  = beat_in.first ? 1'b0 : stop_r;

    ds           = hdur_pkg::short_size(d[1:0]);
    pos_ext      = {2'b00, pos_cur};
    len_ext      = {2'b00, len_r};
    short_end    = pos_ext + 18'd1 + {15'd0, ds};
    long_hdr_end = pos_ext + 18'd3;
    long_end     = pos_ext + 18'd2 + {10'd0, d};
    skip_dec     = (skip_cur != 8'd0) ? skip_cur - 8'd1 : skip_cur;
    in_range     = pos_cur < len_r;

    phase_nxt = phase_cur;
    skip_nxt  = skip_cur;
    stop_nxt  = stop_cur;
    pos_nxt   = (pos_cur != hdur_pkg::POS_MAX) ? pos_cur + 16'd1 : pos_cur;

    beat_out.out_byte  = d;
    beat_out.rewritten = 1'b0;
    beat_out.invalid   = 1'b0;
    beat_out.last      = in_range && (pos_cur == len_r - 16'd1);

    if (in_range && !stop_cur) begin
      case (phase_cur)
        hdur_pkg::PH_HEADER: begin
          if (d[7:4] == hdur_pkg::TAG_LONG) begin
            if (long_hdr_end > len_ext) begin
              beat_out.invalid = 1'b1;
              stop_nxt         = 1'b1;
            end else begin
              phase_nxt = hdur_pkg::PH_LONG_SIZE;
            end
          end else if (short_end > len_ext) begin
            beat_out.invalid = 1'b1;
            stop_nxt         = 1'b1;
          end else if (ds == 3'd1 && d[3:2] == hdur_pkg::TYPE_LOCAL) begin
            phase_nxt = hdur_pkg::PH_LOCAL_BYTE;
          end else if (ds != 3'd0) begin
            skip_nxt  = {5'd0, ds};
            phase_nxt = hdur_pkg::PH_SKIP;
          end
        end
        hdur_pkg::PH_LONG_SIZE: begin
          if (long_end > len_ext) begin
            beat_out.invalid = 1'b1;
            stop_nxt         = 1'b1;
          end else begin
            skip_nxt  = d;
            phase_nxt = hdur_pkg::PH_LONG_TAG;
          end
        end
        hdur_pkg::PH_LONG_TAG: begin
          phase_nxt = (skip_cur != 8'd0) ? hdur_pkg::PH_SKIP : hdur_pkg::PH_HEADER;
        end
        hdur_pkg::PH_LOCAL_BYTE: begin
          if (d == hdur_pkg::USAGE_JOY || d == hdur_pkg::USAGE_PAD) begin
            beat_out.out_byte  = hdur_pkg::USAGE_MULTI;
            beat_out.rewritten = 1'b1;
          end
          phase_nxt = hdur_pkg::PH_HEADER;
        end
        hdur_pkg::PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 8'd0) phase_nxt = hdur_pkg::PH_HEADER;
        end
        default: begin
          phase_nxt = hdur_pkg::PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= 16'd0;
      phase_r <= hdur_pkg::PH_HEADER;
      pos_r   <= 16'd0;
      skip_r  <= 8'd0;
      stop_r  <= 1'b0;
    end else begin
      if (cfg_we) len_r <= cfg_wdata;
      if (step) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        skip_r  <= skip_nxt;
        stop_r  <= stop_nxt;
      end
    end
  end

endmodule

// ===== rtl/hdur_out_reg.sv =====
// ----------------------------------------------------------------------------
// hdur_out_reg
// Result register: holds one beat until the sink takes it.
// ----------------------------------------------------------------------------
module hdur_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  hdur_pkg::hdur_out_t  load_data,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hdur_pkg::hdur_out_t  out_data
);

  logic                valid_r, valid_nxt;
  hdur_pkg::hdur_out_t data_r;

  // a new beat may enter in the cycle the held one leaves
  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= load_data;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== rtl/hdur_checker.sv =====
// ----------------------------------------------------------------------------
// hdur_checker
// Port-level checks on the rewriter, bound to the top level.
// ----------------------------------------------------------------------------
`include "hid_descriptor_usage_rewriter_macros.svh"

module hdur_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input hdur_pkg::hdur_out_t out_data
);

  `HDUR_ASSERT_NEXT(a_out_hold, clk, rst_n,
                    out_valid && !out_ready,
                    out_valid && $stable(out_data))
  `HDUR_ASSERT_NOW(a_rewrite_value, clk, rst_n,
                   out_valid && out_data.rewritten,
                   out_data.out_byte == hdur_pkg::USAGE_MULTI && !out_data.invalid)
  `HDUR_ASSERT_NEXT(a_beat_out, clk, rst_n, in_valid && in_ready, out_valid)
  `HDUR_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind hid_descriptor_usage_rewriter hdur_checker u_hdur_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// ===== test/hid_descriptor_usage_rewriter_tb.sv =====
// ----------------------------------------------------------------------------
// hid_descriptor_usage_rewriter_tb
// Self-checking bench for the HID descriptor usage rewriter.
// ----------------------------------------------------------------------------
// Directed descriptors cover usage rewrites, exact fits, overruns, zero and
// changed lengths, then random descriptors run with random idling on both
// channels, a long receiver stall, and a final idle-free stretch. Every result
// beat is checked against a predictor built into the bench.
module hid_descriptor_usage_rewriter_tb;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 150;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [hdur_pkg::LenW-1:0]     cfg_wdata;
  logic                          in_valid;
  logic                          in_ready;
  hdur_pkg::hdur_in_t            in_data;
  logic                          out_valid;
  logic                          out_ready;
  hdur_pkg::hdur_out_t           out_data;

  // predictor state
  logic [hdur_pkg::LenW-1:0]     desc_len;
  logic [hdur_pkg::PhaseW-1:0]   phase;
  logic [hdur_pkg::LenW-1:0]     position;
  logic [hdur_pkg::ByteW-1:0]    skip_count;
  logic                          stopped;

  hdur_pkg::hdur_out_t           expected_beats[$];
  logic [hdur_pkg::ByteW-1:0]    desc_bytes[$];
  int unsigned                   fail_count;
  int unsigned                   sent_total;
  int unsigned                   quiet_cycles;
  bit                            idle_enable;
  bit                            hold_request;

  hid_descriptor_usage_rewriter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned short_data_count(input logic [1:0] code);
    int unsigned cnt;
    case (code)
      2'd0: cnt = 0;
      2'd1: cnt = 1;
      2'd2: cnt = 2;
      default: cnt = 4;
    endcase
    return cnt;
  endfunction

  // Advances the parse by one byte and returns the beat it should produce.
  function automatic hdur_pkg::hdur_out_t predict_usage_rewrite(
      input hdur_pkg::hdur_in_t item);
    hdur_pkg::hdur_out_t res;
    int unsigned         lim;
    int unsigned         at;
    int unsigned         dsize;
    logic [7:0]          d;
    d = item.data_byte;
    lim = 32'(desc_len);
    if (item.first) begin
      phase = hdur_pkg::PH_HEADER;
      position = '0;
      skip_count = '0;
      stopped = 1'b0;
    end
    at = 32'(position);
    res.out_byte = d;
    res.rewritten = 1'b0;
    res.invalid = 1'b0;
    res.last = 1'b0;
    if (at < lim) begin
      if (at == lim - 1) res.last = 1'b1;
      if (!stopped) begin
        case (phase)
          hdur_pkg::PH_HEADER: begin
            if (d[7:4] == hdur_pkg::TAG_LONG) begin
              // header, size and tag bytes must all fit
              if (at + 3 > lim) begin
                res.invalid = 1'b1;
                stopped = 1'b1;
              end else begin
                phase = hdur_pkg::PH_LONG_SIZE;
              end
            end else begin
              dsize = short_data_count(d[1:0]);
              if (at + 1 + dsize > lim) begin
                res.invalid = 1'b1;
                stopped = 1'b1;
              end else if (dsize == 1 && d[3:2] == hdur_pkg::TYPE_LOCAL) begin
                phase = hdur_pkg::PH_LOCAL_BYTE;
              end else if (dsize > 0) begin
                skip_count = hdur_pkg::ByteW'(dsize);
                phase = hdur_pkg::PH_SKIP;
              end
            end
          end
          hdur_pkg::PH_LONG_SIZE: begin
            if (at + 2 + d > lim) begin
              res.invalid = 1'b1;
              stopped = 1'b1;
            end else begin
              skip_count = d;
              phase = hdur_pkg::PH_LONG_TAG;
            end
          end
          hdur_pkg::PH_LONG_TAG: begin
            phase = (skip_count != 0) ? hdur_pkg::PH_SKIP : hdur_pkg::PH_HEADER;
          end
          hdur_pkg::PH_LOCAL_BYTE: begin
            if (d == hdur_pkg::USAGE_JOY || d == hdur_pkg::USAGE_PAD) begin
              res.out_byte = hdur_pkg::USAGE_MULTI;
              res.rewritten = 1'b1;
            end
            phase = hdur_pkg::PH_HEADER;
          end
          hdur_pkg::PH_SKIP: begin
            if (skip_count > 0) skip_count = skip_count - 8'd1;
            if (skip_count == 0) phase = hdur_pkg::PH_HEADER;
          end
          default: begin
            phase = hdur_pkg::PH_HEADER;
          end
        endcase
      end
    end
    if (position != hdur_pkg::POS_MAX) position = position + 16'd1;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  // Offers one beat, optionally after a random gap, and records its prediction.
  task automatic send_byte(input logic [7:0] d, input logic f);
    hdur_pkg::hdur_in_t item;
    item.data_byte = d;
    item.first = f;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    expected_beats.push_back(predict_usage_rewrite(item));
    sent_total++;
  endtask

  task automatic send_desc(input logic mark_first);
    for (int i = 0; i < desc_bytes.size(); i++)
      send_byte(desc_bytes[i], mark_first && i == 0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  // Length register is only touched with nothing in flight.
  task automatic set_length(input logic [hdur_pkg::LenW-1:0] len);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    desc_len = len;
  endtask

  task automatic add_random_item();
    int unsigned kind;
    int unsigned cnt;
    logic [3:0]  tag;
    logic [1:0]  ty;
    logic [1:0]  code;
    logic [7:0]  sz;
    kind = $urandom_range(0, 9);
    tag = 4'($urandom_range(0, 14));
    ty = 2'($urandom);
    code = 2'($urandom);
    if (kind < 5) begin
      // one-byte local item, biased towards the usages that get rewritten
      desc_bytes.push_back({tag, hdur_pkg::TYPE_LOCAL, 2'd1});
      case ($urandom_range(0, 3))
        0: desc_bytes.push_back(hdur_pkg::USAGE_JOY);
        1: desc_bytes.push_back(hdur_pkg::USAGE_PAD);
        2: desc_bytes.push_back(hdur_pkg::USAGE_MULTI);
        default: desc_bytes.push_back(8'($urandom));
      endcase
    end else if (kind < 8) begin
      desc_bytes.push_back({tag, ty, code});
      cnt = short_data_count(code);
      repeat (cnt) desc_bytes.push_back(8'($urandom));
    end else if (kind == 8) begin
      tag = 4'($urandom);
      sz = 8'($urandom_range(0, 5));
      desc_bytes.push_back({hdur_pkg::TAG_LONG, tag});
      desc_bytes.push_back(sz);
      desc_bytes.push_back(8'($urandom));
      repeat (sz) desc_bytes.push_back(8'($urandom));
    end else begin
      desc_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic test_no_first_after_reset();
    set_length(16'd4);
    desc_bytes = '{8'h09, 8'h04, 8'h19, 8'h05};
    send_desc(1'b0);
  endtask

  task automatic test_usage_rewrite();
    set_length(16'd7);
    // global item, local usage left alone, two-byte local item left alone
    desc_bytes = '{8'h95, 8'h04, 8'h09, 8'h08, 8'h0A, 8'h05, 8'h00};
    send_desc(1'b1);
    // past the end: plain pass-through
    desc_bytes = '{8'h09, 8'h04};
    send_desc(1'b0);
  endtask

  task automatic test_exact_fit();
    set_length(16'd4);
    desc_bytes = '{8'hFE, 8'h01, 8'h10, 8'hAA};
    send_desc(1'b1);
    set_length(16'd1);
    desc_bytes = '{8'hC0};
    send_desc(1'b1);
  endtask

  task automatic test_overruns();
    set_length(16'd2);
    desc_bytes = '{8'hFF, 8'h00};
    send_desc(1'b1);
    // long item overruns on its size byte; the parse stays stopped
    set_length(16'd4);
    desc_bytes = '{8'hFE, 8'h04, 8'h09, 8'h04};
    send_desc(1'b1);
    // four-byte short item header on the final byte
    set_length(16'd3);
    desc_bytes = '{8'h05, 8'h01, 8'h0B};
    send_desc(1'b1);
  endtask

  task automatic test_zero_length();
    set_length(16'd0);
    desc_bytes = '{8'h09, 8'h04};
    send_desc(1'b1);
  endtask

  task automatic test_length_change();
    set_length(16'd3);
    desc_bytes = '{8'h05, 8'h01, 8'h09};
    send_desc(1'b1);
    set_length(16'd4);
    desc_bytes = '{hdur_pkg::USAGE_JOY};
    send_desc(1'b0);
  endtask

  task automatic test_random_descriptors(input int unsigned target);
    int unsigned               n;
    logic [hdur_pkg::LenW-1:0] new_len;
    logic                      mark_first;
    while (sent_total < target) begin
      desc_bytes.delete();
      repeat ($urandom_range(1, 12)) add_random_item();
      n = desc_bytes.size();
      case ($urandom_range(0, 9))
        7: new_len = hdur_pkg::LenW'((n > 1) ? $urandom_range(1, n - 1) : n);
        8: new_len = hdur_pkg::LenW'(n + $urandom_range(1, 4));
        9: new_len = hdur_pkg::LenW'($urandom_range(0, 65535));
        default: new_len = hdur_pkg::LenW'(n);
      endcase
      if (new_len != desc_len) set_length(new_len);
      if (target < 900) idle_enable = ($urandom_range(0, 3) != 0);
      mark_first = ($urandom_range(0, 9) != 0);
      send_desc(mark_first);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering beats.
  task automatic test_receiver_backpressure();
    idle_enable = 1'b0;
    desc_bytes.delete();
    repeat (24) add_random_item();
    set_length(hdur_pkg::LenW'(desc_bytes.size()));
    hold_request = 1'b1;
    send_desc(1'b1);
  endtask

  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    hdur_pkg::hdur_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        fail_count++;
        $display("%0t: result beat with none expected, actual %0h", $time, out_data);
      end else begin
        want = expected_beats.pop_front();
        if (out_data.out_byte !== want.out_byte)
          report_mismatch("out_byte", want.out_byte, out_data.out_byte);
        if (out_data.rewritten !== want.rewritten)
          report_mismatch("rewritten", want.rewritten, out_data.rewritten);
        if (out_data.invalid !== want.invalid)
          report_mismatch("invalid", want.invalid, out_data.invalid);
        if (out_data.last !== want.last)
          report_mismatch("last", want.last, out_data.last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[hid_descriptor_usage_rewriter] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    desc_len = '0;
    phase = hdur_pkg::PH_HEADER;
    position = '0;
    skip_count = '0;
    stopped = 1'b0;
    fail_count = 0;
    sent_total = 0;
    quiet_cycles = 0;
    idle_enable = 1'b1;
    hold_request = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_no_first_after_reset();
    test_usage_rewrite();
    test_exact_fit();
    test_overruns();
    test_zero_length();
    test_length_change();
    test_random_descriptors(800);
    test_receiver_backpressure();
    // closing stretch runs without idling on either side
    idle_enable = 1'b0;
    test_random_descriptors(950);

    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && expected_beats.size() == 0)
      $display("[hid_descriptor_usage_rewriter] OK");
    else
      $display("[hid_descriptor_usage_rewriter] ERROR");
    $finish;
  end

endmodule

// ===== hid_descriptor_usage_rewriter.f =====
+incdir+rtl
rtl/hdur_pkg.sv
rtl/hdur_parser.sv
rtl/hdur_out_reg.sv
rtl/hid_descriptor_usage_rewriter.sv
rtl/hdur_checker.sv
test/hid_descriptor_usage_rewriter_tb.sv
